@@ hw/rtl/iss_pkg.sv @@
// shared types and constants of the integer set store
package iss_pkg;

  localparam int unsigned DefaultCapacity = 16;
  localparam int unsigned ValueW          = 32;
  localparam int unsigned OpW             = 3;
  localparam int unsigned IndexW          = 4;
  localparam int unsigned CountOutW       = 5;

  // operation codes of an input word
  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_QUERY  = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_e;

  // one result word
  typedef struct packed {
    logic                     found;
    logic [CountOutW-1:0]     count;
    logic                     rejected;
    logic signed [ValueW-1:0] read_data;
  } result_t;

endpackage

@@ hw/rtl/iss_if.sv @@
// valid/ready channels for the input and result words
interface iss_in_if;
  import iss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           op;
  logic signed [ValueW-1:0] value;
  logic [IndexW-1:0]        index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);
endinterface

interface iss_out_if;
  import iss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [CountOutW-1:0]     count;
  logic                     rejected;
  logic signed [ValueW-1:0] read_data;

  modport source (output valid, output found, output count, output rejected,
                  output read_data, input ready);
  modport sink   (input valid, input found, input count, input rejected,
                  input read_data, output ready);
endinterface

@@ hw/rtl/iss_mem.sv @@
// element memory: one write port, one registered read port
module iss_mem #(
  parameter int unsigned Depth = iss_pkg::DefaultCapacity,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [iss_pkg::ValueW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [iss_pkg::ValueW-1:0] rdata_o
);
  import iss_pkg::*;

  logic [ValueW-1:0] mem_q [Depth];
  logic [ValueW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/iss_ctrl.sv @@
// sequencer: scans, appends, shifts down and reads through the shared comparator
module iss_ctrl #(
  parameter int unsigned Capacity = iss_pkg::DefaultCapacity,
  parameter int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1,
  parameter int unsigned CntW     = $clog2(Capacity + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  iss_in_if.sink                     in_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output iss_pkg::result_t           res_o,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output logic [iss_pkg::ValueW-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  input  logic [iss_pkg::ValueW-1:0] mem_rdata_i
);
  import iss_pkg::*;

  // width that holds both an index and a count
  localparam int unsigned XW = (CntW > IndexW) ? CntW : IndexW;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic [CntW-1:0]   pend_idx_q, pend_idx_d;
  logic [OpW-1:0]    op_q, op_d;
  logic [ValueW-1:0] value_q, value_d;
  logic              found_q, found_d;
  logic              rejected_q, rejected_d;
  logic [ValueW-1:0] rd_q, rd_d;
  logic              hit;
  logic              more;
  logic [XW-1:0]     in_idx_ext;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  // working registers of the current word
  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    pend_idx_q <= pend_idx_d;
    op_q       <= op_d;
    value_q    <= value_d;
    found_q    <= found_d;
    rejected_q <= rejected_d;
    rd_q       <= rd_d;
  end

  // shared comparator and scan bound
  assign hit        = pend_q && (mem_rdata_i == value_q);
  assign more       = (ptr_q < count_q);
  assign in_idx_ext = XW'(in_i.index);

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    op_d        = op_q;
    value_d     = value_q;
    found_d     = found_q;
    rejected_d  = rejected_q;
    rd_d        = rd_q;
    in_i.ready  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = value_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          op_d       = in_i.op;
          value_d    = in_i.value;
          found_d    = 1'b0;
          rejected_d = 1'b0;
          rd_d       = '0;
          ptr_d      = '0;
          pend_d     = 1'b0;
          case (in_i.op)
            OP_INSERT, OP_REMOVE, OP_QUERY, OP_CLEAR: begin
              state_d = S_SCAN;
            end
            OP_READ: begin
              if (in_idx_ext < XW'(count_q)) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AddrW'(in_idx_ext);
                state_d     = S_READ;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // look for the value, one entry a cycle
      S_SCAN: begin
        if (hit || (!more && !pend_q)) begin
          found_d = hit;
          pend_d  = 1'b0;
          state_d = S_DONE;
          case (op_q)
            OP_INSERT: begin
              if (!hit) begin
                if (count_q < CntW'(Capacity)) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = AddrW'(count_q);
                  mem_wdata_o = value_q;
                  count_d     = count_q + 1'b1;
                end else begin
                  rejected_d = 1'b1;
                end
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                ptr_d   = pend_idx_q + 1'b1;
                state_d = S_SHIFT;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end else if (more) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AddrW'(ptr_q);
          ptr_d       = ptr_q + 1'b1;
          pend_d      = 1'b1;
          pend_idx_d  = ptr_q;
        end else begin
          pend_d = 1'b0;
        end
      end

      // move later entries down one place
      S_SHIFT: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AddrW'(pend_idx_q - 1'b1);
          mem_wdata_o = mem_rdata_i;
        end
        if (more) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AddrW'(ptr_q);
          ptr_d       = ptr_q + 1'b1;
          pend_d      = 1'b1;
          pend_idx_d  = ptr_q;
        end else begin
          pend_d  = 1'b0;
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end

      // entry arrives from the read port
      S_READ: begin
        found_d = 1'b1;
        rd_d    = mem_rdata_i;
        state_d = S_DONE;
      end

      // hand the result word over
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.found     = found_q;
  assign res_o.count     = CountOutW'(count_q);
  assign res_o.rejected  = rejected_q;
  assign res_o.read_data = rd_q;

endmodule

@@ hw/rtl/integer_set_store.sv @@
// top level of the integer set store
//
// Holds up to CAPACITY distinct signed 32-bit values in insertion order in a
// single-port-read memory. One word is taken at a time, and the input is not
// ready until that word's result has left the sequencer. Insert, remove, query
// and clear scan the stored entries through one comparator, one entry per cycle
// behind the registered memory read. A miss scans every stored entry; a hit at
// position k stops the scan there. A remove that hits then moves each later
// entry down one place, one entry per cycle. A read inside the count fetches
// the entry through the read port; a read past the count and an unused op code
// go straight to the result. The result sits in an output register, so the
// next word is accepted while it waits. Every word gives exactly one result
// word. An insert of a new value into a full store is dropped and flagged as
// rejected.
module integer_set_store #(
  parameter int unsigned CAPACITY = iss_pkg::DefaultCapacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iss_in_if.sink     in_i,
  iss_out_if.source  out_o
);
  import iss_pkg::*;

  localparam int unsigned AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [ValueW-1:0] mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic [ValueW-1:0] mem_rdata;
  logic              out_valid_q;
  result_t           out_q;

  iss_ctrl #(
    .Capacity (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  iss_mem #(
    .Depth (CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register between the sequencer and the result channel
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.found     = out_q.found;
  assign out_o.count     = out_q.count;
  assign out_o.rejected  = out_q.rejected;
  assign out_o.read_data = out_q.read_data;

endmodule
